[sv/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef logic signed [WORD_W-1:0] t_word;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_in;   // push at front: every word moves one cell back
        logic shift_out;  // pop at front: every word moves one cell forward
        logic put_rear;   // push at rear: the cell at the fill count loads
    } t_cell_ctl;

endpackage

[sv/cdq_if.sv]
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channels for the circular deque unit: request and result.
// ----------------------------------------------------------------------------
interface cdq_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           op;
    logic signed [cdq_pkg::WORD_W-1:0] push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface cdq_out_if #(
    parameter int CNT_W = 5
);
    logic                 valid;
    logic                 ready;
    logic signed [cdq_pkg::WORD_W-1:0] popped_value;
    logic [1:0]           status;
    logic [CNT_W-1:0]     occupancy;
    logic                 is_empty;
    logic                 is_full;

    modport source (output valid, output popped_value, output status,
                    output occupancy, output is_empty, output is_full,
                    input ready);
    modport sink   (input valid, input popped_value, input status,
                    input occupancy, input is_empty, input is_full,
                    output ready);
endinterface

[sv/cdq_cell.sv]
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of the deque chain. Holds one word, takes its neighbor's
// word on a front push or pop, loads the new word on a rear push when it is
// the first free cell, and offers its word as the rear tap when it is last.
// ----------------------------------------------------------------------------
module cdq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                  i_clk,
    input  cdq_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_W-1:0]      i_count,
    input  cdq_pkg::t_word        i_push_word,
    input  cdq_pkg::t_word        i_prev_word,
    input  cdq_pkg::t_word        i_next_word,
    output cdq_pkg::t_word        o_word,
    output cdq_pkg::t_word        o_rear_tap
);

    cdq_pkg::t_word r_word;
    cdq_pkg::t_word n_word;
    logic           w_is_free_head;
    logic           w_is_rear;

    assign w_is_free_head = (i_count == CNT_W'(IDX));
    assign w_is_rear      = (i_count == CNT_W'(IDX + 1));

    always_comb begin
        n_word = r_word;
        priority if (i_ctl.shift_in) begin
            n_word = (IDX == 0) ? i_push_word : i_prev_word;
        end else if (i_ctl.shift_out) begin
            n_word = i_next_word;
        end else if (i_ctl.put_rear && w_is_free_head) begin
            n_word = i_push_word;
        end else begin
            n_word = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_rear_tap = w_is_rear ? r_word : '0;

endmodule

[sv/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed 32-bit words held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request word: op (push front, push rear, pop front,
//   pop rear) and push_value. o_out returns one result word per request:
//   popped_value, status (ok, overflow, underflow), occupancy after the
//   operation, and empty and full flags.
//   The front word always sits in cell 0 and the rear word in the cell just
//   below the fill count; a front push or pop moves every cell one step.
//   The result is loaded into the output register on acceptance; one request
//   is taken every cycle while the result side drains.
//   When the receiver stalls, the held result stays and i_in.ready drops
//   until it is taken. The rear read is an and-or over all DEPTH cells,
//   which sets the cycle time for large DEPTH.
//   Reset empties the deque at once (fill count cleared); no clearing pass.
//   Failed pushes and pops leave the contents unchanged.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdq_in_if.sink      i_in,
    cdq_out_if.source   o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    cdq_pkg::t_word       r_out_popped;
    cdq_pkg::t_status     r_out_status;
    logic [CNT_W-1:0]     r_out_occ;
    cdq_pkg::t_word       n_popped;
    cdq_pkg::t_status     n_status;
    cdq_pkg::t_cell_ctl   w_ctl;
    cdq_pkg::t_op         w_op;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    cdq_pkg::t_word       w_word [DEPTH];
    cdq_pkg::t_word       w_tap  [DEPTH];
    cdq_pkg::t_word       w_rear;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_op       = cdq_pkg::t_op'(i_in.op);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_rear = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rear = w_rear | w_tap[k];
        end
    end

    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_popped = '0;
        n_status = cdq_pkg::ST_OK;
        unique case (w_op)
            cdq_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    w_ctl.shift_in = w_accept;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            cdq_pkg::OP_PUSH_REAR: begin
                if (w_full) begin
                    n_status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    w_ctl.put_rear = w_accept;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            cdq_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    w_ctl.shift_out = w_accept;
                    n_popped        = w_word[0];
                    n_count         = r_count - CNT_W'(1);
                end
            end
            cdq_pkg::OP_POP_REAR: begin
                if (w_empty) begin
                    n_status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    n_popped = w_rear;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = cdq_pkg::ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        cdq_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_push_word (i_in.push_value),
            .i_prev_word (w_word[(g == 0) ? 0 : g - 1]),
            .i_next_word (w_word[(g == DEPTH - 1) ? g : g + 1]),
            .o_word      (w_word[g]),
            .o_rear_tap  (w_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_popped <= n_popped;
            r_out_status <= n_status;
            r_out_occ    <= n_count;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.popped_value = r_out_popped;
    assign o_out.status       = r_out_status;
    assign o_out.occupancy    = r_out_occ;
    assign o_out.is_empty     = (r_out_occ == '0);
    assign o_out.is_full      = (r_out_occ == CNT_W'(DEPTH));

endmodule

[verif/cdq_checker.sv]
// ----------------------------------------------------------------------------
// cdq_checker
// Watches the request and result channels of the circular deque unit. It
// keeps its own copy of the deque, works out the result word for every
// accepted request, and compares each accepted result word field by field
// against the oldest outstanding one.
// ----------------------------------------------------------------------------
module cdq_checker #(
    parameter int DEPTH = 16,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cdq_in_if    i_req,
    cdq_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct {
        cdq_pkg::t_word   popped;
        cdq_pkg::t_status status;
        logic [CNT_W-1:0] occupancy;
        logic             is_empty;
        logic             is_full;
    } t_outcome;

    cdq_pkg::t_word slot_mem [DEPTH];
    int             head_pos;
    int             fill_level;
    t_outcome       outcome_q [$];
    t_outcome       want;
    int             error_count;

    initial begin
        head_pos     = 0;
        fill_level   = 0;
        error_count  = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // applies one operation to the local deque and returns its result word
    function automatic t_outcome deque_step(cdq_pkg::t_op op, cdq_pkg::t_word value);
        t_outcome r;
        int       idx;
        r.popped = '0;
        r.status = cdq_pkg::ST_OK;
        case (op)
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
                if (fill_level == DEPTH) begin
                    r.status = cdq_pkg::ST_OVERFLOW;
                end else begin
                    if (op == cdq_pkg::OP_PUSH_FRONT) begin
                        head_pos = (head_pos == 0) ? DEPTH - 1 : head_pos - 1;
                        idx      = head_pos;
                    end else begin
                        idx = (head_pos + fill_level) % DEPTH;
                    end
                    slot_mem[idx] = value;
                    fill_level++;
                end
            end
            default: begin
                if (fill_level == 0) begin
                    r.status = cdq_pkg::ST_UNDERFLOW;
                end else begin
                    if (op == cdq_pkg::OP_POP_FRONT) begin
                        idx      = head_pos;
                        head_pos = (head_pos + 1) % DEPTH;
                    end else begin
                        idx = (head_pos + fill_level - 1) % DEPTH;
                    end
                    r.popped = slot_mem[idx];
                    fill_level--;
                end
            end
        endcase
        r.occupancy = CNT_W'(fill_level);
        r.is_empty  = (fill_level == 0);
        r.is_full   = (fill_level == DEPTH);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_pos   = 0;
            fill_level = 0;
            outcome_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (outcome_q.size() == 0) begin
                    if (error_count < 10)
                        $display("%0t: result word with none outstanding", $time);
                    error_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (i_res.popped_value !== want.popped ||
                        i_res.status !== want.status ||
                        i_res.occupancy !== want.occupancy ||
                        i_res.is_empty !== want.is_empty ||
                        i_res.is_full !== want.is_full) begin
                        if (error_count < 10)
                            $display("%0t: exp %0d %0d %0d %0b %0b, got %0d %0d %0d %0b %0b",
                                     $time, want.popped, want.status, want.occupancy,
                                     want.is_empty, want.is_full,
                                     i_res.popped_value, i_res.status,
                                     i_res.occupancy, i_res.is_empty, i_res.is_full);
                        error_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                outcome_q.push_back(deque_step(cdq_pkg::t_op'(i_req.op),
                                               i_req.push_value));
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= error_count;
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the circular deque unit. A short directed run
// covers empty and full boundaries, front wrap-around and extreme words;
// then random bursts lean toward filling, draining or mixing, so the deque
// keeps reaching both ends. Both sides idle at random, and a checker beside
// the unit predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH        = 16;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RAND_ITEMS   = 950;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   fail_count;
    int   pending;
    int   dead_cycles;

    cdq_in_if                    req_ch ();
    cdq_out_if #(.CNT_W(CNT_W))  res_ch ();

    circular_deque_unit #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    cdq_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(negedge i_clk)
        res_ch.ready <= steady || ($urandom_range(99) >= 17);

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
        if (dead_cycles >= STALL_LIMIT) begin
            $display("circular_deque_unit: mismatch");
            $finish;
        end
    end

    function automatic cdq_pkg::t_word pick_word();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return '0;
                default: return '1;
            endcase
        end
        return cdq_pkg::t_word'($urandom);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input cdq_pkg::t_op op, input cdq_pkg::t_word value);
        while (!steady && $urandom_range(99) < 17) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.push_value <= value;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int           n;
        int           burst_left;
        int           push_pct;
        cdq_pkg::t_op op;

        burst_left        = 0;
        push_pct          = 50;
        steady            = 1'b0;
        dead_cycles       = 0;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.op         = cdq_pkg::OP_PUSH_FRONT;
        req_ch.push_value = '0;
        res_ch.ready      = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both pops on empty, then front push wraps the head below zero
        send_word(cdq_pkg::OP_POP_FRONT, 32'sh7fff_ffff);
        send_word(cdq_pkg::OP_POP_REAR, 32'sh8000_0000);
        send_word(cdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
        send_word(cdq_pkg::OP_PUSH_REAR, 32'sh7fff_ffff);
        send_word(cdq_pkg::OP_POP_FRONT, '0);
        send_word(cdq_pkg::OP_POP_REAR, '1);
        send_word(cdq_pkg::OP_PUSH_FRONT, 32'sh5555_5555);
        send_word(cdq_pkg::OP_PUSH_REAR, 32'shaaaa_aaaa);
        // fill to full from both ends, then overflow on both
        for (n = 0; n < DEPTH - 2; n++)
            send_word((n % 2) ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_REAR,
                      pick_word());
        send_word(cdq_pkg::OP_PUSH_FRONT, '1);
        send_word(cdq_pkg::OP_PUSH_REAR, '0);

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0:       push_pct = 80;
                    1:       push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            burst_left--;
            steady = (n >= 300 && n < 450);
            if (n == 600) begin
                req_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (pending != 0)
                    @(negedge i_clk);
            end
            if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
            else
                op = $urandom_range(1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
            send_word(op, pick_word());
        end
        req_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("circular_deque_unit: match");
        else
            $display("circular_deque_unit: mismatch");
        $finish;
    end

endmodule
